### src/ffa_pkg.sv
// Shared types and constants for the first-fit free-list allocator.
package ffa_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_BITS     = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int OUT_CNT_W     = 13;
  localparam int TOTAL_W       = 33;

  localparam logic [31:0] ROUND_ADD  = 32'h0000_0fff;
  localparam logic [31:0] ROUND_KEEP = 32'hffff_f000;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NO_FIT = 2'd1;
  localparam logic [1:0] STAT_LOST   = 2'd2;

  typedef struct packed {
    logic        command;
    logic        page_round;
    logic [31:0] address;
    logic [31:0] request_size;
  } req_t;

  typedef struct packed {
    logic [31:0]          granted_address;
    logic [1:0]           status;
    logic [TOTAL_W-1:0]   total_free;
    logic [OUT_CNT_W-1:0] free_entries;
    logic [OUT_CNT_W-1:0] peak_entries;
    logic [31:0]          lost_count;
    logic [31:0]          lost_bytes;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [31:0]          size;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

### src/first_fit_free_list_allocator.sv
// Top level: address-sorted free-region table with first-fit allocate and coalescing free.
//
// One request at a time. The region table sits in a single memory with one
// read and one write port and a registered read. Allocate: a streaming scan
// from entry 0 until the first region large enough, then a write-back, or,
// when the region empties, a shift of the entries above it down by one (one
// entry per cycle). Free: a scan until the first region starting above the
// freed address, a decision state, then on insert a shift up of the entries
// above the slot, or on a double merge a shift down, plus one write; a free
// that merges with nothing while the table is full is dropped and counted.
// The scan and the shift cover opposite ends of the table, so together they
// touch each entry about once. The output register holds a finished response
// while the next request is accepted. No clearing pass is needed: only
// entries below the entry count are ever read. Total free bytes are kept as
// a running sum, updated by the size change of each step.
module first_fit_free_list_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ffa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ffa_pkg::rsp_t rsp
);

  localparam int IW = ffa_pkg::IDX_W;
  localparam int CW = ffa_pkg::CNT_W;
  localparam int AW = ffa_pkg::ADDR_BITS;
  localparam int TW = ffa_pkg::TOTAL_W;
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_MAX = CW'(ffa_pkg::TABLE_ENTRIES);

  // region table
  ffa_pkg::entry_t mem [ffa_pkg::TABLE_ENTRIES];
  ffa_pkg::entry_t rd_data;
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  ffa_pkg::entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  ffa_pkg::state_t state, state_next;

  // architectural counters
  logic [CW-1:0] entry_count;
  logic [CW-1:0] peak_count;
  logic [31:0]   dropped_frees;
  logic [31:0]   dropped_bytes;
  logic [TW-1:0] free_total;

  // request context
  logic          cmd_r;
  logic [AW-1:0] at_r;
  logic [31:0]   size_r;
  logic [31:0]   res_grant;
  logic [1:0]    res_status;

  // scan
  logic [CW-1:0]   scan_idx;
  logic            chk_valid;
  logic [IW-1:0]   chk_idx;
  logic [CW-1:0]   k_r;
  ffa_pkg::entry_t prev_r;
  ffa_pkg::entry_t next_r;

  // shift engine and final write
  logic [CW-1:0]   sh_src;
  logic [CW-1:0]   sh_left;
  logic            sh_up;
  logic            pw_valid;
  logic [IW-1:0]   pw_dst;
  logic            write_after;
  logic [IW-1:0]   wr_idx;
  ffa_pkg::entry_t wr_entry;

  // scan checks
  logic        scan_issue, alloc_hit, free_hit, hit, scan_end;
  logic [31:0] alloc_left;
  // free decision
  logic        join_prev, join_next;
  logic [31:0] sz_both, sz_prev, sz_next;
  logic        sh_issue;
  logic        rsp_load;

  assign alloc_hit  = chk_valid && (rd_data.size >= size_r);
  assign free_hit   = chk_valid && (rd_data.start > at_r);
  assign hit        = (cmd_r == ffa_pkg::CMD_FREE) ? free_hit : alloc_hit;
  assign scan_issue = (scan_idx < entry_count) && !hit;
  assign scan_end   = hit || (scan_idx == entry_count);
  assign alloc_left = rd_data.size - size_r;

  assign join_prev = (k_r != '0) && ((prev_r.start + AW'(prev_r.size)) == at_r);
  assign join_next = (k_r < entry_count) && ((at_r + AW'(size_r)) == next_r.start);
  assign sz_prev   = prev_r.size + size_r;
  assign sz_both   = sz_prev + next_r.size;
  assign sz_next   = next_r.size + size_r;

  assign sh_issue  = (sh_left != '0);
  assign req_ready = (state == ffa_pkg::ST_IDLE);
  assign rsp_load  = (state == ffa_pkg::ST_DONE) && (!rsp_valid || rsp_ready);

  // next state and table port control
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = scan_idx[IW-1:0];
    wr_en      = 1'b0;
    wr_addr    = wr_idx;
    wr_data    = wr_entry;
    unique case (state)
      ffa_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = ffa_pkg::ST_SCAN;
        end
      end
      ffa_pkg::ST_SCAN: begin
        rd_en = scan_issue;
        if (scan_end) begin
          if (cmd_r == ffa_pkg::CMD_FREE) begin
            state_next = ffa_pkg::ST_DECIDE;
          end else if (!hit) begin
            state_next = ffa_pkg::ST_DONE;
          end else if (alloc_left == '0) begin
            state_next = ffa_pkg::ST_SHIFT;
          end else begin
            state_next = ffa_pkg::ST_WRITE;
          end
        end
      end
      ffa_pkg::ST_DECIDE: begin
        priority if (join_prev && join_next) begin
          state_next = ffa_pkg::ST_SHIFT;
        end else if (join_prev || join_next) begin
          state_next = ffa_pkg::ST_WRITE;
        end else if (entry_count < CNT_MAX) begin
          state_next = ffa_pkg::ST_SHIFT;
        end else begin
          state_next = ffa_pkg::ST_DONE;
        end
      end
      ffa_pkg::ST_SHIFT: begin
        rd_en   = sh_issue;
        rd_addr = sh_src[IW-1:0];
        wr_en   = pw_valid;
        wr_addr = pw_dst;
        wr_data = rd_data;
        if (!sh_issue) begin
          state_next = write_after ? ffa_pkg::ST_WRITE : ffa_pkg::ST_DONE;
        end
      end
      ffa_pkg::ST_WRITE: begin
        wr_en      = 1'b1;
        state_next = ffa_pkg::ST_DONE;
      end
      ffa_pkg::ST_DONE: begin
        if (rsp_load) begin
          state_next = ffa_pkg::ST_IDLE;
        end
      end
      default: state_next = ffa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      peak_count    <= '0;
      dropped_frees <= '0;
      dropped_bytes <= '0;
      free_total    <= '0;
      chk_valid     <= 1'b0;
      pw_valid      <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      chk_valid <= (state == ffa_pkg::ST_SCAN) && scan_issue;
      pw_valid  <= (state == ffa_pkg::ST_SHIFT) && sh_issue;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if ((state == ffa_pkg::ST_SCAN) && scan_end && (cmd_r == ffa_pkg::CMD_ALLOC) && hit) begin
        free_total <= free_total - TW'(size_r);
        if (alloc_left == '0) begin
          entry_count <= entry_count - CNT_ONE;
        end
      end
      if (state == ffa_pkg::ST_DECIDE) begin
        priority if (join_prev && join_next) begin
          free_total  <= free_total - TW'(prev_r.size) - TW'(next_r.size) + TW'(sz_both);
          entry_count <= entry_count - CNT_ONE;
        end else if (join_prev) begin
          free_total <= free_total - TW'(prev_r.size) + TW'(sz_prev);
        end else if (join_next) begin
          free_total <= free_total - TW'(next_r.size) + TW'(sz_next);
        end else if (entry_count < CNT_MAX) begin
          free_total  <= free_total + TW'(size_r);
          entry_count <= entry_count + CNT_ONE;
          if ((entry_count + CNT_ONE) > peak_count) begin
            peak_count <= entry_count + CNT_ONE;
          end
        end else begin
          dropped_frees <= dropped_frees + 32'd1;
          dropped_bytes <= dropped_bytes + size_r;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ffa_pkg::ST_IDLE: begin
        cmd_r      <= req.command;
        at_r       <= AW'(req.address);
        size_r     <= req.page_round ? ((req.request_size + ffa_pkg::ROUND_ADD)
                                        & ffa_pkg::ROUND_KEEP)
                                     : req.request_size;
        scan_idx   <= '0;
        res_grant  <= '0;
        res_status <= ffa_pkg::STAT_OK;
      end
      ffa_pkg::ST_SCAN: begin
        chk_idx <= scan_idx[IW-1:0];
        if (scan_issue) begin
          scan_idx <= scan_idx + CNT_ONE;
        end
        if (cmd_r == ffa_pkg::CMD_FREE) begin
          if (chk_valid && !free_hit) begin
            prev_r <= rd_data;
          end
          if (scan_end) begin
            k_r    <= free_hit ? CW'(chk_idx) : entry_count;
            next_r <= rd_data;
          end
        end else if (scan_end) begin
          if (hit) begin
            res_grant   <= 32'(rd_data.start);
            wr_idx      <= chk_idx;
            wr_entry    <= '{start: rd_data.start + AW'(size_r), size: alloc_left};
            sh_src      <= CW'(chk_idx) + CNT_ONE;
            sh_left     <= entry_count - CNT_ONE - CW'(chk_idx);
            sh_up       <= 1'b0;
            write_after <= 1'b0;
          end else begin
            res_status <= ffa_pkg::STAT_NO_FIT;
          end
        end
      end
      ffa_pkg::ST_DECIDE: begin
        priority if (join_prev && join_next) begin
          wr_idx      <= IW'(k_r - CNT_ONE);
          wr_entry    <= '{start: prev_r.start, size: sz_both};
          sh_src      <= k_r + CNT_ONE;
          sh_left     <= entry_count - CNT_ONE - k_r;
          sh_up       <= 1'b0;
          write_after <= 1'b1;
        end else if (join_prev) begin
          wr_idx   <= IW'(k_r - CNT_ONE);
          wr_entry <= '{start: prev_r.start, size: sz_prev};
        end else if (join_next) begin
          wr_idx   <= IW'(k_r);
          wr_entry <= '{start: at_r, size: sz_next};
        end else if (entry_count < CNT_MAX) begin
          wr_idx      <= IW'(k_r);
          wr_entry    <= '{start: at_r, size: size_r};
          sh_src      <= entry_count - CNT_ONE;
          sh_left     <= entry_count - k_r;
          sh_up       <= 1'b1;
          write_after <= 1'b1;
        end else begin
          res_status <= ffa_pkg::STAT_LOST;
        end
      end
      ffa_pkg::ST_SHIFT: begin
        if (sh_issue) begin
          sh_left <= sh_left - CNT_ONE;
          sh_src  <= sh_up ? (sh_src - CNT_ONE) : (sh_src + CNT_ONE);
          pw_dst  <= sh_up ? IW'(sh_src + CNT_ONE) : IW'(sh_src - CNT_ONE);
        end
      end
      ffa_pkg::ST_WRITE: begin
      end
      ffa_pkg::ST_DONE: begin
        if (rsp_load) begin
          rsp.granted_address <= res_grant;
          rsp.status          <= res_status;
          rsp.total_free      <= free_total;
          rsp.free_entries    <= ffa_pkg::OUT_CNT_W'(entry_count);
          rsp.peak_entries    <= ffa_pkg::OUT_CNT_W'(peak_count);
          rsp.lost_count      <= dropped_frees;
          rsp.lost_bytes      <= dropped_bytes;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_MAX) else $error("entry count above table size");
  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    peak_count >= entry_count) else $error("peak below entry count");
  a_lost_full: assert property (@(posedge clk) disable iff (rst)
    rsp_load && (res_status == ffa_pkg::STAT_LOST) |-> entry_count == CNT_MAX)
    else $error("free dropped with room in table");
  a_shift_write: assert property (@(posedge clk) disable iff (rst)
    pw_valid |-> state == ffa_pkg::ST_SHIFT) else $error("shift write outside shift");
`endif

endmodule
